@@ rtl/dpwc_pkg.sv @@
// ---------------------------------------------------------------------------
// Dirty page write counter package
// Shared constants, item structs, status codes and controller types.
// ---------------------------------------------------------------------------
package dpwc_pkg;

  // Table size and derived widths
  localparam int unsigned TableDepth = 1024;
  localparam int unsigned SlotW      = $clog2(TableDepth);
  localparam int unsigned UsedW      = $clog2(TableDepth + 1);

  // Soft-dirty flag position in the pagemap word
  localparam int unsigned DirtyBit   = 55;

  // Result status codes
  typedef enum logic [2:0] {
    STAT_CLEAN    = 3'd0,
    STAT_COUNTED  = 3'd1,
    STAT_INSERTED = 3'd2,
    STAT_FULL     = 3'd3,
    STAT_READ     = 3'd4
  } status_e;

  // Input item
  typedef struct packed {
    logic        kind;
    logic [35:0] page_number;
    logic [63:0] pagemap_entry;
    logic [9:0]  read_slot;
  } in_item_t;

  // Result item
  typedef struct packed {
    status_e     status;
    logic [9:0]  slot;
    logic [31:0] dirty_count;
    logic [35:0] page_out;
    logic        slot_valid;
    logic [10:0] entries_used;
  } out_item_t;

  // One table entry held by a cell
  typedef struct packed {
    logic [35:0] key;
    logic [31:0] count;
  } entry_t;

  // Controls from the controller to the ring of cells
  typedef struct packed {
    logic   shift;
    logic   load;
    entry_t load_entry;
  } ring_ctrl_t;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_SEARCH,
    ST_SEEK
  } state_e;

endpackage

@@ rtl/dpwc_cell.sv @@
// ---------------------------------------------------------------------------
// Dirty page write counter ring cell
// Holds one table entry; rotates it to its neighbour or takes a new value.
// ---------------------------------------------------------------------------
module dpwc_cell (
  input  logic            clk_i,
  input  logic            shift_i,
  input  logic            load_i,
  input  dpwc_pkg::entry_t load_entry_i,
  input  dpwc_pkg::entry_t nbr_i,
  output dpwc_pkg::entry_t entry_o
);

  dpwc_pkg::entry_t entry_q, entry_d;

  // A write has priority over rotation
  always_comb begin
    entry_d = entry_q;
    if (load_i) begin
      entry_d = load_entry_i;
    end else if (shift_i) begin
      entry_d = nbr_i;
    end
  end

  // Payload only, no reset
  always_ff @(posedge clk_i) begin
    if (load_i || shift_i) begin
      entry_q <= entry_d;
    end
  end

  assign entry_o = entry_q;

endmodule

@@ rtl/dpwc_ctrl.sv @@
// ---------------------------------------------------------------------------
// Dirty page write counter controller
// Sequences lookups, inserts and reads over the rotating ring of cells.
// ---------------------------------------------------------------------------
module dpwc_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  dpwc_pkg::in_item_t   in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output dpwc_pkg::out_item_t  out_item_o,
  input  dpwc_pkg::entry_t     head_i,
  output dpwc_pkg::ring_ctrl_t ring_o
);

  localparam int unsigned SlotW = dpwc_pkg::SlotW;
  localparam int unsigned UsedW = dpwc_pkg::UsedW;

  dpwc_pkg::state_e    state_q, state_d;
  dpwc_pkg::in_item_t  item_q;
  dpwc_pkg::out_item_t out_q, res;
  logic                out_valid_q, out_valid_d;
  logic [SlotW-1:0]    head_slot_q, head_slot_d;
  logic [UsedW-1:0]    used_q, used_d;
  logic [UsedW-1:0]    cnt_q, cnt_d;
  logic [SlotW-1:0]    tgt_q, tgt_d;
  logic                ins_q, ins_d;
  logic                emit;

  logic             out_free, head_occ, hit, scan_last, full, rd_ok, dirty, at_tgt;
  logic [31:0]      cnt_inc;
  logic [UsedW-1:0] used_inc;

  // Status decode around the head cell
  always_comb begin
    out_free  = !out_valid_q || out_ready_i;
    head_occ  = UsedW'(head_slot_q) < used_q;
    hit       = head_occ && (head_i.key == item_q.page_number);
    scan_last = cnt_q == UsedW'(dpwc_pkg::TableDepth - 1);
    full      = used_q == UsedW'(dpwc_pkg::TableDepth);
    rd_ok     = (32'(item_q.read_slot) < 32'(used_q)) &&
                (32'(item_q.read_slot) < dpwc_pkg::TableDepth);
    dirty     = item_q.pagemap_entry[dpwc_pkg::DirtyBit];
    at_tgt    = head_slot_q == tgt_q;
    cnt_inc   = (head_i.count == '1) ? head_i.count : head_i.count + 32'd1;
    used_inc  = used_q + UsedW'(1);
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      dpwc_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = dpwc_pkg::ST_EVAL;
      end
      dpwc_pkg::ST_EVAL: begin
        if (item_q.kind) begin
          if (rd_ok) state_d = dpwc_pkg::ST_SEEK;
          else if (out_free) state_d = dpwc_pkg::ST_IDLE;
        end else if (dirty) begin
          state_d = dpwc_pkg::ST_SEARCH;
        end else if (out_free) begin
          state_d = dpwc_pkg::ST_IDLE;
        end
      end
      dpwc_pkg::ST_SEARCH: begin
        if (hit) begin
          if (out_free) state_d = dpwc_pkg::ST_IDLE;
        end else if (scan_last) begin
          if (!full) state_d = dpwc_pkg::ST_SEEK;
          else if (out_free) state_d = dpwc_pkg::ST_IDLE;
        end
      end
      dpwc_pkg::ST_SEEK: begin
        if (at_tgt && out_free) state_d = dpwc_pkg::ST_IDLE;
      end
      default: state_d = dpwc_pkg::ST_IDLE;
    endcase
  end

  // Datapath controls and result assembly
  always_comb begin
    ring_o.shift      = 1'b0;
    ring_o.load       = 1'b0;
    ring_o.load_entry = '{key: item_q.page_number, count: 32'd1};
    emit              = 1'b0;
    cnt_d             = cnt_q;
    tgt_d             = tgt_q;
    ins_d             = ins_q;
    used_d            = used_q;
    res.status        = dpwc_pkg::STAT_CLEAN;
    res.slot          = '0;
    res.dirty_count   = '0;
    res.page_out      = item_q.page_number;
    res.slot_valid    = 1'b0;
    res.entries_used  = 11'(used_q);
    unique case (state_q)
      dpwc_pkg::ST_IDLE: begin
        cnt_d = '0;
      end
      dpwc_pkg::ST_EVAL: begin
        tgt_d = SlotW'(item_q.read_slot);
        ins_d = 1'b0;
        if (item_q.kind) begin
          // read of an empty slot answers at once
          res.status   = dpwc_pkg::STAT_READ;
          res.slot     = item_q.read_slot;
          res.page_out = '0;
          emit         = !rd_ok && out_free;
        end else begin
          emit = !dirty && out_free;
        end
      end
      dpwc_pkg::ST_SEARCH: begin
        if (hit) begin
          res.status      = dpwc_pkg::STAT_COUNTED;
          res.slot        = 10'(head_slot_q);
          res.dirty_count = cnt_inc;
          res.slot_valid  = 1'b1;
          ring_o.load_entry.count = cnt_inc;
          ring_o.load     = out_free;
          emit            = out_free;
        end else if (scan_last) begin
          // whole ring seen without a match
          tgt_d      = SlotW'(used_q);
          ins_d      = 1'b1;
          res.status = dpwc_pkg::STAT_FULL;
          emit       = full && out_free;
        end else begin
          ring_o.shift = 1'b1;
          cnt_d        = cnt_q + UsedW'(1);
        end
      end
      dpwc_pkg::ST_SEEK: begin
        if (at_tgt) begin
          res.slot_valid = 1'b1;
          emit           = out_free;
          if (ins_q) begin
            res.status       = dpwc_pkg::STAT_INSERTED;
            res.slot         = 10'(tgt_q);
            res.dirty_count  = 32'd1;
            res.entries_used = 11'(used_inc);
            ring_o.load      = out_free;
            if (out_free) used_d = used_inc;
          end else begin
            res.status      = dpwc_pkg::STAT_READ;
            res.slot        = item_q.read_slot;
            res.dirty_count = head_i.count;
            res.page_out    = head_i.key;
          end
        end else begin
          ring_o.shift = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Slot number at the head follows the rotation
  always_comb begin
    head_slot_d = head_slot_q;
    if (ring_o.shift) begin
      head_slot_d = (head_slot_q == SlotW'(dpwc_pkg::TableDepth - 1)) ? '0
                                                                      : head_slot_q + SlotW'(1);
    end
  end

  // Output register valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dpwc_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
      head_slot_q <= '0;
      used_q      <= '0;
      cnt_q       <= '0;
      tgt_q       <= '0;
      ins_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      head_slot_q <= head_slot_d;
      used_q      <= used_d;
      cnt_q       <= cnt_d;
      tgt_q       <= tgt_d;
      ins_q       <= ins_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) item_q <= in_item_i;
    if (emit) out_q <= res;
  end

  assign in_ready_o  = state_q == dpwc_pkg::ST_IDLE;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

@@ rtl/dirty_page_write_counter_top.sv @@
// ---------------------------------------------------------------------------
// Dirty page write counter
// Counts soft-dirty samples per page in a rotating ring of table cells.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o/in_item_i) takes one item at a time:
//   a pagemap sample (kind 0) or a slot read (kind 1). Output channel
//   (out_valid_o/out_ready_i/out_item_o) gives exactly one result per item.
//   The table is a ring of TableDepth cells that rotates by one place per
//   cycle while a search or seek is under way; only the cell at the head of
//   the ring is compared or written. A clean sample or a read of an empty
//   slot is answered from the evaluation state with no rotation. A dirty
//   sample rotates the ring in a search until a hit or a full turn; after a
//   miss the ring turns on to the first free slot for the insert, unless the
//   table is full. A read of an occupied slot turns the ring to that slot.
//   One item is worked on at a time and the next is taken the cycle after
//   the result is registered.
//   Reset empties the table (fill count to zero) with no clearing pass.
//   A stalled receiver holds the result in the output register; a finished
//   item waits there until taken, while a new item may already be accepted.
// ---------------------------------------------------------------------------
module dirty_page_write_counter_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  dpwc_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output dpwc_pkg::out_item_t out_item_o
);

  localparam int unsigned Depth = dpwc_pkg::TableDepth;

  dpwc_pkg::entry_t     cell_q [Depth];
  dpwc_pkg::ring_ctrl_t ring;

  // Sequencer
  dpwc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o),
    .head_i      (cell_q[0]),
    .ring_o      (ring)
  );

  // Ring of cells: each takes its entry from the next one, the last from the head
  for (genvar i = 0; i < Depth; i++) begin : g_cell
    dpwc_cell u_cell (
      .clk_i        (clk_i),
      .shift_i      (ring.shift),
      .load_i       ((i == 0) ? ring.load : 1'b0),
      .load_entry_i (ring.load_entry),
      .nbr_i        (cell_q[(i + 1) % Depth]),
      .entry_o      (cell_q[i])
    );
  end

endmodule
